>>> hw/rtl/svf_ap_pkg.sv
// ============================================================================
// svf_ap_pkg: shared types, constants and microcode for the SVF allpass
// Holds the request payload types, datapath widths, the control word layout
// and the read-only microprogram that sequences one sample through the
// shared multiply-accumulate datapath.
// ============================================================================
package svf_ap_pkg;

  // Sample and state widths.
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned STATE_W     = 32;
  localparam int unsigned COEF_W      = 31;
  localparam int unsigned K_W         = 30;
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned CFG_IDX_W   = 2;

  // Coefficient limits: unity in Q1.30 and 1000.0 in Q10.20.
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1073741824);
  localparam logic [K_W-1:0]    K_LIMIT  = K_W'(64'd1048576000);

  // Datapath widths. The multiplier takes a signed data operand and a
  // non-negative coefficient operand.
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W;
  localparam int unsigned V3_W    = STATE_W + 1;
  localparam int unsigned V1_W    = MUL_A_W;
  localparam int unsigned V2_W    = MUL_A_W;
  localparam int unsigned UPD_W   = V1_W + 2;

  // Rounding shifts for the integrator terms and the output term.
  localparam int unsigned SH_V = 30;
  localparam int unsigned SH_Y = 19;
  localparam int unsigned Y_W  = ACC_W - SH_Y + 1;

  // Round-half-up offsets preloaded into the accumulator.
  localparam logic signed [ACC_W-1:0] RND_V = ACC_W'(64'd1 << (SH_V - 1));
  localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(64'd1 << (SH_Y - 1));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A1   = 2'd0,
    CFG_COEF_A2   = 2'd1,
    CFG_COEF_A3   = 2'd2,
    CFG_DAMPING_K = 2'd3
  } cfg_reg_e;

  // Request payloads.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          channel_out;
  } out_req_t;

  // Microprogram addresses.
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_V3   = 3'd1;
  localparam logic [STEP_W-1:0] ST_AV3  = 3'd2;
  localparam logic [STEP_W-1:0] ST_AS1  = 3'd3;
  localparam logic [STEP_W-1:0] ST_V1   = 3'd4;
  localparam logic [STEP_W-1:0] ST_KV1  = 3'd5;
  localparam logic [STEP_W-1:0] ST_V2   = 3'd6;
  localparam logic [STEP_W-1:0] ST_OUT  = 3'd7;

  // Sequencing operations.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_DONE
  } seq_op_e;

  // Multiplier operand selects.
  typedef enum logic [1:0] {
    MA_S1,
    MA_V3,
    MA_V1
  } mul_a_sel_e;

  typedef enum logic [1:0] {
    MB_A1,
    MB_A2,
    MB_A3,
    MB_K
  } mul_b_sel_e;

  // Accumulator preload.
  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_RND_V,
    ACC_RND_Y
  } acc_init_e;

  // One control word of the microprogram.
  typedef struct packed {
    seq_op_e           seq;
    logic [STEP_W-1:0] jmp;
    logic              load;
    logic              mul_en;
    mul_a_sel_e        mul_a;
    mul_b_sel_e        mul_b;
    acc_init_e         acc_init;
    logic              acc_add;
    logic              v3_ld;
    logic              v1_ld;
    logic              v2_ld;
    logic              s1_wr;
    logic              finish;
  } ctrl_t;

  // Handshake status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_status_t;

  localparam ctrl_t CTRL_NOP = '{
    seq:      SEQ_NEXT,
    jmp:      ST_IDLE,
    load:     1'b0,
    mul_en:   1'b0,
    mul_a:    MA_S1,
    mul_b:    MB_A1,
    acc_init: ACC_KEEP,
    acc_add:  1'b0,
    v3_ld:    1'b0,
    v1_ld:    1'b0,
    v2_ld:    1'b0,
    s1_wr:    1'b0,
    finish:   1'b0
  };

  // Microprogram ROM. A product is registered and added in the next step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (step)
      // Wait for a sample and latch it with its integrator pair.
      ST_IDLE: begin
        c.seq  = SEQ_WAIT_IN;
        c.load = 1'b1;
      end
      // v3 = x - s2; start a1*s1.
      ST_V3: begin
        c.v3_ld    = 1'b1;
        c.mul_en   = 1'b1;
        c.mul_a    = MA_S1;
        c.mul_b    = MB_A1;
        c.acc_init = ACC_RND_V;
      end
      // Accumulate a1*s1; start a2*v3.
      ST_AV3: begin
        c.acc_add = 1'b1;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_V3;
        c.mul_b   = MB_A2;
      end
      // Accumulate a2*v3; start a2*s1.
      ST_AS1: begin
        c.acc_add = 1'b1;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_S1;
        c.mul_b   = MB_A2;
      end
      // Take v1; restart the sum with a2*s1; start a3*v3.
      ST_V1: begin
        c.v1_ld    = 1'b1;
        c.acc_init = ACC_RND_V;
        c.acc_add  = 1'b1;
        c.mul_en   = 1'b1;
        c.mul_a    = MA_V3;
        c.mul_b    = MB_A3;
      end
      // Accumulate a3*v3; start k*v1.
      ST_KV1: begin
        c.acc_add = 1'b1;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_V1;
        c.mul_b   = MB_K;
      end
      // Take v2, update s1, start the output sum with k*v1.
      ST_V2: begin
        c.v2_ld    = 1'b1;
        c.s1_wr    = 1'b1;
        c.acc_init = ACC_RND_Y;
        c.acc_add  = 1'b1;
      end
      // Update s2 and present the result once the output slot is free.
      ST_OUT: begin
        c.seq    = SEQ_DONE;
        c.jmp    = ST_IDLE;
        c.finish = 1'b1;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

  // Saturate an integrator update to the signed state range.
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [UPD_W-1:0] v
  );
    logic [UPD_W-STATE_W:0] top;
    logic signed [STATE_W-1:0] r;
    top = v[UPD_W-1:STATE_W-1];
    if ((&top) || (~|top)) begin
      r = v[STATE_W-1:0];
    end else if (v[UPD_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/svf_ap_useq.sv
// ============================================================================
// svf_ap_useq: microprogram sequencer
// Steps through the control ROM, holds at the wait steps until the input
// request arrives or the output slot frees, and issues one control word per
// cycle with the handshake-dependent actions masked.
// ============================================================================
module svf_ap_useq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  svf_ap_pkg::seq_status_t   status_i,
  output svf_ap_pkg::ctrl_t         ctrl_o,
  output logic                      in_ready_o
);

  logic [svf_ap_pkg::STEP_W-1:0] step_q;
  logic [svf_ap_pkg::STEP_W-1:0] step_d;
  svf_ap_pkg::ctrl_t             word;

  // Control ROM lookup.
  assign word = svf_ap_pkg::ucode(step_q);

  // Next step, with the conditional jumps.
  always_comb begin
    unique case (word.seq)
      svf_ap_pkg::SEQ_NEXT: begin
        step_d = step_q + 1'b1;
      end
      svf_ap_pkg::SEQ_WAIT_IN: begin
        step_d = status_i.in_valid ? step_q + 1'b1 : step_q;
      end
      svf_ap_pkg::SEQ_DONE: begin
        step_d = status_i.out_free ? word.jmp : step_q;
      end
      default: begin
        step_d = svf_ap_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs: loading and finishing only when the handshake allows.
  always_comb begin
    ctrl_o        = word;
    ctrl_o.load   = word.load & status_i.in_valid;
    ctrl_o.finish = word.finish & status_i.out_free;
    in_ready_o    = (word.seq == svf_ap_pkg::SEQ_WAIT_IN);
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= svf_ap_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> hw/rtl/svf_ap_mac.sv
// ============================================================================
// svf_ap_mac: shared multiply-accumulate unit
// One signed multiplier with a product register, followed by an accumulator
// that can be preloaded with a rounding offset and add the held product.
// ============================================================================
module svf_ap_mac (
  input  logic                                      clk_i,
  input  svf_ap_pkg::ctrl_t                         ctrl_i,
  input  logic signed [svf_ap_pkg::MUL_A_W-1:0]     mul_a_i,
  input  logic signed [svf_ap_pkg::MUL_B_W-1:0]     mul_b_i,
  output logic signed [svf_ap_pkg::ACC_W-1:0]       acc_o
);

  logic signed [svf_ap_pkg::PROD_W-1:0] prod_q;
  logic signed [svf_ap_pkg::PROD_W-1:0] prod_d;
  logic signed [svf_ap_pkg::ACC_W-1:0]  acc_q;
  logic signed [svf_ap_pkg::ACC_W-1:0]  acc_d;
  logic signed [svf_ap_pkg::ACC_W-1:0]  acc_base;

  // Full-width signed product.
  assign prod_d = svf_ap_pkg::PROD_W'(mul_a_i) * svf_ap_pkg::PROD_W'(mul_b_i);

  // Accumulator base: keep the running sum or restart at a rounding offset.
  always_comb begin
    unique case (ctrl_i.acc_init)
      svf_ap_pkg::ACC_KEEP:  acc_base = acc_q;
      svf_ap_pkg::ACC_RND_V: acc_base = svf_ap_pkg::RND_V;
      svf_ap_pkg::ACC_RND_Y: acc_base = svf_ap_pkg::RND_Y;
      default:               acc_base = acc_q;
    endcase
    acc_d = ctrl_i.acc_add ? acc_base + prod_q : acc_base;
  end

  // Product and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

>>> hw/rtl/svf_ap_dp.sv
// ============================================================================
// svf_ap_dp: allpass datapath
// Holds the per-channel integrator pairs, the working registers of one
// sample, the operand selection for the shared multiply-accumulate unit,
// the saturating updates and the output register.
// ============================================================================
module svf_ap_dp #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  svf_ap_pkg::ctrl_t                     ctrl_i,
  input  svf_ap_pkg::in_req_t                   in_req_i,
  input  logic [svf_ap_pkg::COEF_W-1:0]         coef_a1_i,
  input  logic [svf_ap_pkg::COEF_W-1:0]         coef_a2_i,
  input  logic [svf_ap_pkg::COEF_W-1:0]         coef_a3_i,
  input  logic [svf_ap_pkg::K_W-1:0]            damping_k_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output svf_ap_pkg::out_req_t                  out_req_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SB    = svf_ap_pkg::SAMPLE_BITS;
  localparam int unsigned YW    = svf_ap_pkg::Y_W;

  // Integrator pairs, one per channel.
  logic signed [svf_ap_pkg::STATE_W-1:0] s1_mem_q [CHANNELS];
  logic signed [svf_ap_pkg::STATE_W-1:0] s2_mem_q [CHANNELS];

  // Working registers of the sample in flight.
  logic signed [SB-1:0]                  x_q;
  logic                                  ch_q;
  logic [IDX_W-1:0]                      idx_q;
  logic signed [svf_ap_pkg::STATE_W-1:0] s1_q;
  logic signed [svf_ap_pkg::STATE_W-1:0] s2_q;
  logic signed [svf_ap_pkg::V3_W-1:0]    v3_q;
  logic signed [svf_ap_pkg::V1_W-1:0]    v1_q;
  logic signed [svf_ap_pkg::V2_W-1:0]    v2_q;

  logic                                  out_valid_q;
  svf_ap_pkg::out_req_t                  out_q;

  logic [IDX_W-1:0]                      idx_in;
  logic signed [svf_ap_pkg::MUL_A_W-1:0] mul_a;
  logic signed [svf_ap_pkg::MUL_B_W-1:0] mul_b;
  logic signed [svf_ap_pkg::ACC_W-1:0]   acc;
  logic signed [svf_ap_pkg::ACC_W-1:0]   acc_sh_v;
  logic signed [svf_ap_pkg::ACC_W-1:0]   acc_sh_y;
  logic signed [svf_ap_pkg::V3_W-1:0]    v3_d;
  logic signed [svf_ap_pkg::V1_W-1:0]    v1_d;
  logic signed [svf_ap_pkg::V2_W-1:0]    v2_d;
  logic signed [svf_ap_pkg::STATE_W-1:0] s1_new;
  logic signed [svf_ap_pkg::STATE_W-1:0] s2_new;
  logic signed [YW-1:0]                  y_full;
  logic [YW-SB:0]                        y_top;
  logic signed [SB-1:0]                  y_sat;

  // The channel selects its pair modulo the channel count.
  assign idx_in = (CHANNELS > 1) ? IDX_W'(in_req_i.channel) : '0;

  // Multiplier operand selection.
  always_comb begin
    unique case (ctrl_i.mul_a)
      svf_ap_pkg::MA_S1: mul_a = svf_ap_pkg::MUL_A_W'(s1_q);
      svf_ap_pkg::MA_V3: mul_a = svf_ap_pkg::MUL_A_W'(v3_q);
      svf_ap_pkg::MA_V1: mul_a = v1_q;
      default:           mul_a = '0;
    endcase
    unique case (ctrl_i.mul_b)
      svf_ap_pkg::MB_A1: mul_b = $signed(svf_ap_pkg::MUL_B_W'(coef_a1_i));
      svf_ap_pkg::MB_A2: mul_b = $signed(svf_ap_pkg::MUL_B_W'(coef_a2_i));
      svf_ap_pkg::MB_A3: mul_b = $signed(svf_ap_pkg::MUL_B_W'(coef_a3_i));
      svf_ap_pkg::MB_K:  mul_b = $signed(svf_ap_pkg::MUL_B_W'(damping_k_i));
      default:           mul_b = '0;
    endcase
  end

  svf_ap_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .acc_o   (acc)
  );

  // Intermediate values and rounded accumulator results.
  always_comb begin
    acc_sh_v = acc >>> svf_ap_pkg::SH_V;
    acc_sh_y = acc >>> svf_ap_pkg::SH_Y;
    v3_d = svf_ap_pkg::V3_W'(x_q) - svf_ap_pkg::V3_W'(s2_q);
    v1_d = $signed(acc_sh_v[svf_ap_pkg::V1_W-1:0]);
    v2_d = svf_ap_pkg::V2_W'(s2_q) + $signed(acc_sh_v[svf_ap_pkg::V2_W-1:0]);
  end

  // Saturating integrator updates: 2*v - s.
  always_comb begin
    s1_new = svf_ap_pkg::sat_state(
      (svf_ap_pkg::UPD_W'(v1_q) <<< 1) - svf_ap_pkg::UPD_W'(s1_q));
    s2_new = svf_ap_pkg::sat_state(
      (svf_ap_pkg::UPD_W'(v2_q) <<< 1) - svf_ap_pkg::UPD_W'(s2_q));
  end

  // Output y = x - round(k*v1 / 2^19), saturated to the sample range.
  always_comb begin
    y_full = YW'(x_q) - YW'($signed(acc_sh_y[YW-2:0]));
    y_top  = y_full[YW-1:SB-1];
    if ((&y_top) || (~|y_top)) begin
      y_sat = y_full[SB-1:0];
    end else if (y_full[YW-1]) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Integrator storage, cleared on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        s1_mem_q[i] <= '0;
        s2_mem_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.s1_wr) begin
        s1_mem_q[idx_q] <= s1_new;
      end
      if (ctrl_i.finish) begin
        s2_mem_q[idx_q] <= s2_new;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q   <= in_req_i.sample_in;
      ch_q  <= in_req_i.channel;
      idx_q <= idx_in;
      s1_q  <= s1_mem_q[idx_in];
      s2_q  <= s2_mem_q[idx_in];
    end
    if (ctrl_i.v3_ld) begin
      v3_q <= v3_d;
    end
    if (ctrl_i.v1_ld) begin
      v1_q <= v1_d;
    end
    if (ctrl_i.v2_ld) begin
      v2_q <= v2_d;
    end
    if (ctrl_i.finish) begin
      out_q.sample_out  <= y_sat;
      out_q.channel_out <= ch_q;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> hw/rtl/tpt_svf_allpass_filter_top.sv
// A sample request is latched in the wait step, passes the steps V3, AV3, AS1, V1, KV1, V2
// and OUT, and its result is registered when OUT finishes. Only one sample is in work at a
// time; the single shared multiplier is used five times per sample.
// A new sample is accepted while the previous result still waits in the output register.
// Reset clears both integrators of every channel and loads the reset coefficients.
// ============================================================================
// tpt_svf_allpass_filter_top: two-channel TPT state-variable allpass
// Configuration registers, microcoded sequencer and datapath of a
// second-order allpass with saturating 32-bit integrators.
// ============================================================================
module tpt_svf_allpass_filter_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  svf_ap_pkg::in_req_t                 in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output svf_ap_pkg::out_req_t                out_req_o,
  input  logic                                cfg_we_i,
  input  logic [svf_ap_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svf_ap_pkg::CFG_W-1:0]        cfg_data_i
);

  logic [svf_ap_pkg::COEF_W-1:0] coef_a1_q;
  logic [svf_ap_pkg::COEF_W-1:0] coef_a2_q;
  logic [svf_ap_pkg::COEF_W-1:0] coef_a3_q;
  logic [svf_ap_pkg::K_W-1:0]    damping_k_q;
  logic [svf_ap_pkg::COEF_W-1:0] coef_wr;
  logic [svf_ap_pkg::K_W-1:0]    k_wr;

  svf_ap_pkg::ctrl_t             ctrl;
  svf_ap_pkg::seq_status_t       status;

  // Limit written values: coefficients at unity, damping at 1000.0.
  always_comb begin
    coef_wr = (cfg_data_i > svf_ap_pkg::COEF_ONE) ? svf_ap_pkg::COEF_ONE : cfg_data_i;
    k_wr    = (cfg_data_i[svf_ap_pkg::K_W-1:0] > svf_ap_pkg::K_LIMIT) ?
              svf_ap_pkg::K_LIMIT : cfg_data_i[svf_ap_pkg::K_W-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a1_q   <= svf_ap_pkg::COEF_ONE;
      coef_a2_q   <= '0;
      coef_a3_q   <= '0;
      damping_k_q <= '0;
    end else if (cfg_we_i) begin
      unique case (svf_ap_pkg::cfg_reg_e'(cfg_idx_i))
        svf_ap_pkg::CFG_COEF_A1:   coef_a1_q   <= coef_wr;
        svf_ap_pkg::CFG_COEF_A2:   coef_a2_q   <= coef_wr;
        svf_ap_pkg::CFG_COEF_A3:   coef_a3_q   <= coef_wr;
        svf_ap_pkg::CFG_DAMPING_K: damping_k_q <= k_wr;
        default: begin
        end
      endcase
    end
  end

  // Handshake status for the sequencer.
  always_comb begin
    status.in_valid = in_valid_i;
    status.out_free = !out_valid_o || out_ready_i;
  end

  svf_ap_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  svf_ap_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_req_i    (in_req_i),
    .coef_a1_i   (coef_a1_q),
    .coef_a2_i   (coef_a2_q),
    .coef_a3_i   (coef_a3_q),
    .damping_k_i (damping_k_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  // One sample at a time: an accepted request closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while a sample is in work");

  // A result only appears when the program finishes a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.finish))
    else $error("output valid without a finished sample");

  // Finishing never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> (!out_valid_o || out_ready_i))
    else $error("result written into an occupied output register");

  // Loading happens only in the wait step together with an input request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> (in_ready_o && in_valid_i))
    else $error("sample loaded outside an input handshake");
`endif

endmodule

>>> verif/tpt_svf_allpass_filter_top_tb.sv
// ============================================================================
// tpt_svf_allpass_filter_top_tb: self-checking bench for the SVF allpass
// Streams signed samples on both channels through the filter under several
// coefficient settings, predicts every output with a fixed-point copy of the
// filter and compares each result request field by field, in order.
// ============================================================================
module tpt_svf_allpass_filter_top_tb;

  localparam int unsigned NUM_CH = 2;
  // A comfortable margin after the last result has come back.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_PRINTED   = 50;
  localparam int unsigned SB            = svf_ap_pkg::SAMPLE_BITS;

  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  svf_ap_pkg::in_req_t                 in_req_i    = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  svf_ap_pkg::out_req_t                out_req_o;
  logic                                cfg_we_i    = 1'b0;
  logic [svf_ap_pkg::CFG_IDX_W-1:0]    cfg_idx_i   = svf_ap_pkg::CFG_COEF_A1;
  logic [svf_ap_pkg::CFG_W-1:0]        cfg_data_i  = '0;

  // Predicted filter configuration and integrator state.
  logic [svf_ap_pkg::COEF_W-1:0]         coef_a1_q = svf_ap_pkg::COEF_ONE;
  logic [svf_ap_pkg::COEF_W-1:0]         coef_a2_q = '0;
  logic [svf_ap_pkg::COEF_W-1:0]         coef_a3_q = '0;
  logic [svf_ap_pkg::K_W-1:0]            damping_q = '0;
  logic signed [svf_ap_pkg::STATE_W-1:0] integ_one [NUM_CH] = '{default: '0};
  logic signed [svf_ap_pkg::STATE_W-1:0] integ_two [NUM_CH] = '{default: '0};

  svf_ap_pkg::in_req_t  pending_samples_q [$];
  svf_ap_pkg::out_req_t expected_outs_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_burst    = 0;
  int unsigned recv_burst    = 0;
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  bit          req_taken     = 1'b0;

  tpt_svf_allpass_filter_top #(
    .CHANNELS(NUM_CH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #2000000;
    $display("tpt_svf_allpass_filter_top_tb: done, errors");
    $finish;
  end

  // Round half up: floor(v / 2^sh + 1/2).
  function automatic longint round_half_up(input longint v, input int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint saturate(input longint v, input int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One filter step: updates the channel's integrators and queues the output.
  function automatic void allpass_step(input svf_ap_pkg::in_req_t req);
    longint               x, s1, s2, v3, v1, v2;
    longint               a1, a2, a3, kd;
    int unsigned          idx;
    svf_ap_pkg::out_req_t res;
    x   = longint'($signed(req.sample_in));
    idx = req.channel % NUM_CH;
    a1  = (coef_a1_q > svf_ap_pkg::COEF_ONE) ? longint'(svf_ap_pkg::COEF_ONE) :
          longint'(coef_a1_q);
    a2  = (coef_a2_q > svf_ap_pkg::COEF_ONE) ? longint'(svf_ap_pkg::COEF_ONE) :
          longint'(coef_a2_q);
    a3  = (coef_a3_q > svf_ap_pkg::COEF_ONE) ? longint'(svf_ap_pkg::COEF_ONE) :
          longint'(coef_a3_q);
    kd  = (damping_q > svf_ap_pkg::K_LIMIT) ? longint'(svf_ap_pkg::K_LIMIT) :
          longint'(damping_q);
    s1  = longint'(integ_one[idx]);
    s2  = longint'(integ_two[idx]);
    v3  = x - s2;
    v1  = round_half_up(a1 * s1 + a2 * v3, svf_ap_pkg::SH_V);
    v2  = s2 + round_half_up(a2 * s1 + a3 * v3, svf_ap_pkg::SH_V);
    integ_one[idx] = svf_ap_pkg::STATE_W'(saturate(2 * v1 - s1, svf_ap_pkg::STATE_W));
    integ_two[idx] = svf_ap_pkg::STATE_W'(saturate(2 * v2 - s2, svf_ap_pkg::STATE_W));
    // The output term 2*k*v1 in Q10.20 is k*v1 scaled down by 2^19.
    res.sample_out  = SB'(saturate(x - round_half_up(kd * v1, svf_ap_pkg::SH_Y), SB));
    res.channel_out = req.channel;
    expected_outs_q.push_back(res);
  endfunction

  function automatic void queue_sample(input logic signed [SB-1:0] smp,
                                       input logic ch);
    svf_ap_pkg::in_req_t req;
    req.sample_in = smp;
    req.channel   = ch;
    pending_samples_q.push_back(req);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t: result %0d: %s", $time, results_seen, msg);
    end
  endtask

  // Block until every queued request has gone in and every result came back.
  task automatic wait_for_drain();
    while (pending_samples_q.size() != 0 || in_valid_i || expected_outs_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write the selected registers on consecutive cycles; the filter is idle here.
  task automatic load_coefs(input logic [svf_ap_pkg::CFG_W-1:0] a1,
                            input logic [svf_ap_pkg::CFG_W-1:0] a2,
                            input logic [svf_ap_pkg::CFG_W-1:0] a3,
                            input logic [svf_ap_pkg::CFG_W-1:0] kd,
                            input logic [3:0] which);
    logic [svf_ap_pkg::CFG_W-1:0] vals [4];
    svf_ap_pkg::cfg_reg_e         regs [4];
    vals = '{a1, a2, a3, kd};
    regs = '{svf_ap_pkg::CFG_COEF_A1, svf_ap_pkg::CFG_COEF_A2,
             svf_ap_pkg::CFG_COEF_A3, svf_ap_pkg::CFG_DAMPING_K};
    for (int i = 0; i < 4; i++) begin
      if (which[i]) begin
        @(negedge clk_i);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= regs[i];
        cfg_data_i <= vals[i];
      end
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Track register writes and accepted sample requests at the clock edge.
  always @(posedge clk_i) begin : track_requests
    if (cfg_we_i) begin
      case (cfg_idx_i)
        svf_ap_pkg::CFG_COEF_A1:   coef_a1_q = cfg_data_i[svf_ap_pkg::COEF_W-1:0];
        svf_ap_pkg::CFG_COEF_A2:   coef_a2_q = cfg_data_i[svf_ap_pkg::COEF_W-1:0];
        svf_ap_pkg::CFG_COEF_A3:   coef_a3_q = cfg_data_i[svf_ap_pkg::COEF_W-1:0];
        svf_ap_pkg::CFG_DAMPING_K: damping_q = cfg_data_i[svf_ap_pkg::K_W-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && in_ready_o) begin
      allpass_step(in_req_i);
      req_taken = 1'b1;
    end
  end

  // Sample driver: presents the next pending request, with random gaps.
  always @(negedge clk_i) begin : drive_samples
    bit go;
    if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (send_burst != 0) begin
        send_burst--;
        go = 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) send_burst = $urandom_range(8, 40);
        go = $urandom_range(0, 99) >= send_idle_pct;
      end
      if (rst_ni && go && pending_samples_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= pending_samples_q.pop_front();
      end else begin
        in_valid_i         <= 1'b0;
        in_req_i.sample_in <= SB'($urandom);
        in_req_i.channel   <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Result receiver: stalls at random, with stretches of steady acceptance.
  always @(negedge clk_i) begin : drive_ready
    bit take;
    if (recv_burst != 0) begin
      recv_burst--;
      take = 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_burst = $urandom_range(8, 40);
      take = $urandom_range(0, 99) >= recv_idle_pct;
    end
    out_ready_i <= rst_ni && take;
  end

  // Compare every accepted result request with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    svf_ap_pkg::out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_outs_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, sample %0d channel %0d",
                                  $signed(out_req_o.sample_out), out_req_o.channel_out));
      end else begin
        want = expected_outs_q.pop_front();
        if (out_req_o.sample_out !== want.sample_out) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    $signed(out_req_o.sample_out), $signed(want.sample_out)));
        end
        if (out_req_o.channel_out !== want.channel_out) begin
          report_mismatch($sformatf("channel_out %0d, expected %0d",
                                    out_req_o.channel_out, want.channel_out));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                  phase, seg, n, r, ch_mode;
    logic signed [SB-1:0]         smp, last_smp;
    logic                         ch;
    real                          g, kd, den;
    logic [svf_ap_pkg::CFG_W-1:0] ra1, ra2, ra3, rk;
    logic [3:0]                   which;

    last_smp      = '0;
    ch            = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 62;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset coefficients give a straight pass-through of the sample.
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample('0, 1'b0);
    queue_sample(SB'(-1), 1'b1);
    queue_sample(SB'(1), 1'b0);
    wait_for_drain();

    // All-ones registers: every coefficient and the damping clamp to their
    // limits, and full-scale input drives the output and integrators into
    // saturation.
    load_coefs('1, '1, '1, '1, 4'hF);
    for (int i = 0; i < 4; i++) queue_sample(SMP_MAX, 1'b0);
    for (int i = 0; i < 4; i++) queue_sample(SMP_MIN, 1'b1);
    wait_for_drain();

    // Exactly at the limits, with one coefficient just above unity.
    load_coefs(svf_ap_pkg::COEF_ONE, svf_ap_pkg::COEF_W'(svf_ap_pkg::COEF_ONE + 1),
               svf_ap_pkg::COEF_ONE, svf_ap_pkg::CFG_W'(svf_ap_pkg::K_LIMIT), 4'hF);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MAX, 1'b1);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    wait_for_drain();

    // All-zero registers.
    load_coefs('0, '0, '0, '0, 4'hF);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample(SB'(12345), 1'b0);
    wait_for_drain();

    // Random part in three idling phases; the sender pauses to let the
    // filter drain between segments, and the registers change there.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 6; seg++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // A stable filter from a random cutoff gain and damping.
          g     = $urandom_range(1, 3000) / 1000.0;
          kd    = $urandom_range(5, 20000) / 1000.0;
          den   = 1.0 + g * (g + kd);
          ra1   = svf_ap_pkg::CFG_W'($rtoi(1073741824.0 / den));
          ra2   = svf_ap_pkg::CFG_W'($rtoi(1073741824.0 * g / den));
          ra3   = svf_ap_pkg::CFG_W'($rtoi(1073741824.0 * g * g / den));
          rk    = svf_ap_pkg::CFG_W'($rtoi(kd * 1048576.0));
          which = 4'hF;
        end else if (r < 80) begin
          // Arbitrary register contents, often above the limits.
          ra1   = svf_ap_pkg::CFG_W'($urandom);
          ra2   = svf_ap_pkg::CFG_W'($urandom);
          ra3   = svf_ap_pkg::CFG_W'($urandom);
          rk    = svf_ap_pkg::CFG_W'($urandom);
          which = 4'($urandom_range(1, 15));
        end else if (r < 90) begin
          ra1 = '1; ra2 = '1; ra3 = '1; rk = '1;
          which = 4'hF;
        end else begin
          ra1 = '0; ra2 = '0; ra3 = '0; rk = '0;
          which = 4'hF;
        end
        load_coefs(ra1, ra2, ra3, rk, which);

        ch_mode = $urandom_range(0, 2);
        n       = $urandom_range(50, 95);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            smp = SB'($urandom);
          end else if (r < 60) begin
            smp = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
          end else if (r < 80) begin
            smp = SB'($urandom_range(0, 1023)) - SB'(512);
          end else begin
            smp = last_smp;
          end
          last_smp = smp;
          case (ch_mode)
            0:       ch = ~ch;
            1:       ch = 1'($urandom_range(0, 1));
            default: ch = seg[0];
          endcase
          queue_sample(smp, ch);
        end
        wait_for_drain();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tpt_svf_allpass_filter_top_tb: done, clean");
    end else begin
      $display("tpt_svf_allpass_filter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
